// File: src/utl1_pkg.sv
// Shared types and constants of the UTF-16 text to Latin-1 decoder.
package utl1_pkg;

   // Character codes handled by the line-end folding
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_NUL = 8'h00;

   // Code unit limits
   localparam logic [15:0] LATIN1_LIMIT = 16'h0100;
   localparam logic [15:0] HI_SURR_LOW  = 16'hD800;
   localparam logic [15:0] HI_SURR_HIGH = 16'hDBFF;
   localparam logic [15:0] DROP_MAX     = 16'hFFFF;

   // Text mode register codes
   localparam logic MODE_ANSI  = 1'b0;
   localparam logic MODE_UTF16 = 1'b1;

   // Token queue geometry
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Classified word passed from the front to the back
   typedef struct packed {
      logic        is_char;
      logic [7:0]  ch;
      logic        last;
      logic [15:0] dropped;
   } token_type;

   // One result word
   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        end_of_text;
      logic [15:0] dropped_units;
   } result_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: src/utl1_channels.sv
// Channel interfaces of the decoder: request, result and register write.
interface utl1_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        last_unit;
   modport source (output valid, output code_unit, output last_unit, input ready);
   modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

interface utl1_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        byte_valid;
   logic        end_of_text;
   logic [15:0] dropped_units;
   modport source (output valid, output out_byte, output byte_valid,
                   output end_of_text, output dropped_units, input ready);
   modport sink   (input valid, input out_byte, input byte_valid,
                   input end_of_text, input dropped_units, output ready);
endinterface

interface utl1_csr_if;
   logic valid;
   logic ready;
   logic text_mode;
   modport source (output valid, output text_mode, input ready);
   modport sink   (input valid, input text_mode, output ready);
endinterface

// File: src/utl1_front.sv
// Front part: accepts code units, tracks surrogates and drops, emits tokens.
module utl1_front (
   input  logic                       clock,
   input  logic                       reset,
   utl1_req_if.sink                   req_if,
   utl1_csr_if.sink                   csr_if,
   input  utl1_pkg::queue_status_type q_status,
   output logic                       q_push,
   output utl1_pkg::token_type        q_token
);

   logic        mode_ff;
   logic        skip_ff, skip_in;
   logic [15:0] drop_ff, drop_in;
   logic        accept;
   logic        is_char;
   logic [7:0]  ch;
   logic        is_hi_surr;
   logic [15:0] drop_inc;

   assign req_if.ready = !q_status.full;
   assign csr_if.ready = 1'b1;
   assign accept       = req_if.valid && req_if.ready;

   assign is_hi_surr = (req_if.code_unit >= utl1_pkg::HI_SURR_LOW) &&
                       (req_if.code_unit <= utl1_pkg::HI_SURR_HIGH);
   assign drop_inc   = (drop_ff != utl1_pkg::DROP_MAX) ? drop_ff + 16'd1 : drop_ff;

   // Classify the word and work out the message state after it
   always_comb begin
      is_char = 1'b0;
      ch      = req_if.code_unit[7:0];
      skip_in = skip_ff;
      drop_in = drop_ff;
      if (mode_ff == utl1_pkg::MODE_ANSI) begin
         skip_in = 1'b0;
         is_char = 1'b1;
      end else if (skip_ff) begin
         skip_in = 1'b0;
      end else if (req_if.code_unit >= utl1_pkg::LATIN1_LIMIT) begin
         drop_in = drop_inc;
         skip_in = is_hi_surr;
      end else begin
         is_char = 1'b1;
      end
   end

   // Forward only words that change the byte stream
   assign q_push          = accept && (is_char || req_if.last_unit);
   assign q_token.is_char = is_char;
   assign q_token.ch      = ch;
   assign q_token.last    = req_if.last_unit;
   assign q_token.dropped = drop_in;

   // Hold mode, skip flag and drop count; skip flag and drop count clear at message end
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= utl1_pkg::MODE_UTF16;
         skip_ff <= 1'b0;
         drop_ff <= 16'd0;
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            mode_ff <= csr_if.text_mode;
         end
         if (accept) begin
            if (req_if.last_unit) begin
               skip_ff <= 1'b0;
               drop_ff <= 16'd0;
            end else begin
               skip_ff <= skip_in;
               drop_ff <= drop_in;
            end
         end
      end
   end

endmodule

// File: src/utl1_queue.sv
// Short token queue between the front and back parts.
module utl1_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  utl1_pkg::token_type        push_token,
   input  logic                       pop,
   output utl1_pkg::token_type        pop_token,
   output utl1_pkg::queue_status_type status
);

   localparam logic [utl1_pkg::QUEUE_AW:0] DEPTH_CNT =
      (utl1_pkg::QUEUE_AW + 1)'(utl1_pkg::QUEUE_DEPTH);

   utl1_pkg::token_type             slot_ff [utl1_pkg::QUEUE_DEPTH];
   logic [utl1_pkg::QUEUE_AW-1:0]   wr_ptr_ff;
   logic [utl1_pkg::QUEUE_AW-1:0]   rd_ptr_ff;
   logic [utl1_pkg::QUEUE_AW:0]     count_ff;
   logic                            do_push;
   logic                            do_pop;

   assign status.full  = (count_ff == DEPTH_CNT);
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_token    = slot_ff[rd_ptr_ff];

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_token;
      end
   end

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// File: src/utl1_back.sv
// Back part: folds CR LF through the held byte and drives the result register.
module utl1_back (
   input  logic                       clock,
   input  logic                       reset,
   input  utl1_pkg::token_type        q_token,
   input  utl1_pkg::queue_status_type q_status,
   output logic                       q_pop,
   utl1_rsp_if.source                 rsp_if
);

   logic                 held_valid_ff, held_valid_in;
   logic [7:0]           held_byte_ff, held_byte_in;
   logic                 out_valid_ff, out_valid_in;
   utl1_pkg::result_type out_ff, out_in;
   logic                 pend_valid_ff, pend_valid_in;
   utl1_pkg::result_type pend_ff, pend_in;
   logic                 can_load;
   logic                 pushed;
   logic                 nv;
   logic [7:0]           nb;
   utl1_pkg::result_type push_res;
   utl1_pkg::result_type end_res;

   assign can_load = !out_valid_ff || rsp_if.ready;

   // Work out the next held byte, result words and queue pop
   always_comb begin
      held_valid_in = held_valid_ff;
      held_byte_in  = held_byte_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      q_pop         = 1'b0;
      pushed        = 1'b0;
      nv            = held_valid_ff;
      nb            = held_byte_ff;

      push_res.out_byte      = held_byte_ff;
      push_res.byte_valid    = 1'b1;
      push_res.end_of_text   = 1'b0;
      push_res.dropped_units = 16'd0;

      // Fold LF onto a held CR, otherwise push the held byte out
      if (q_token.is_char) begin
         if (q_token.ch == utl1_pkg::CH_LF && held_valid_ff &&
             held_byte_ff == utl1_pkg::CH_CR) begin
            nb = utl1_pkg::CH_LF;
         end else begin
            pushed = held_valid_ff;
            nb     = q_token.ch;
            nv     = 1'b1;
         end
      end

      // End word: release the held byte unless it is the terminator
      end_res.end_of_text   = 1'b1;
      end_res.dropped_units = q_token.dropped;
      if (nv && nb != utl1_pkg::CH_NUL) begin
         end_res.out_byte   = nb;
         end_res.byte_valid = 1'b1;
      end else begin
         end_res.out_byte   = utl1_pkg::CH_NUL;
         end_res.byte_valid = 1'b0;
      end

      if (can_load) begin
         if (pend_valid_ff) begin
            // Drain the second word of the last token
            out_valid_in  = 1'b1;
            out_in        = pend_ff;
            pend_valid_in = 1'b0;
         end else if (!q_status.empty) begin
            q_pop = 1'b1;
            if (q_token.last) begin
               held_valid_in = 1'b0;
               held_byte_in  = utl1_pkg::CH_NUL;
               out_valid_in  = 1'b1;
               if (pushed) begin
                  out_in        = push_res;
                  pend_in       = end_res;
                  pend_valid_in = 1'b1;
               end else begin
                  out_in = end_res;
               end
            end else begin
               held_valid_in = nv;
               held_byte_in  = nb;
               out_valid_in  = pushed;
               out_in        = push_res;
            end
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   // Hold held byte, result register and pending end word
   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_byte_ff  <= utl1_pkg::CH_NUL;
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         held_byte_ff  <= held_byte_in;
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
      out_ff  <= out_in;
      pend_ff <= pend_in;
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.out_byte      = out_ff.out_byte;
   assign rsp_if.byte_valid    = out_ff.byte_valid;
   assign rsp_if.end_of_text   = out_ff.end_of_text;
   assign rsp_if.dropped_units = out_ff.dropped_units;

endmodule

// File: src/utf16_text_to_latin1_lf_decoder.sv
// Top level of the UTF-16 / 8-bit clipboard text to Latin-1 decoder.
//
// req_if carries one code unit per word with last_unit on the final unit of
// a message; rsp_if returns Latin-1 bytes, the last word of each message
// carrying end_of_text and the saturating count of dropped units. csr_if
// writes text_mode (0 = 8-bit units, 1 = UTF-16 units); it is always ready.
// One code unit is taken per cycle while the queue has room. Characters and
// last units pass as tokens through the queue to the back part; a byte appears
// on rsp_if when the next character pushes it out of the one-byte hold, and the
// end word follows the last unit, behind the held byte when that goes out first.
// A last unit that releases two words parks the end word in a pending register
// behind the single result register; otherwise the sustained rate is one unit
// per cycle while rsp_if is ready. When rsp_if stalls, the result register
// holds, the four-entry token queue fills and req_if.ready falls once it is full.
// Reset clears the queue, the held byte, skip flag, drop count and sets
// text_mode to UTF-16; no words are in flight after reset.
module utf16_text_to_latin1_lf_decoder (
   input  logic       clock,
   input  logic       reset,
   utl1_req_if.sink   req_if,
   utl1_rsp_if.source rsp_if,
   utl1_csr_if.sink   csr_if
);

   utl1_pkg::queue_status_type q_status;
   utl1_pkg::token_type        push_token;
   utl1_pkg::token_type        pop_token;
   logic                       q_push;
   logic                       q_pop;

   utl1_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .csr_if   (csr_if),
      .q_status (q_status),
      .q_push   (q_push),
      .q_token  (push_token)
   );

   utl1_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_token (push_token),
      .pop        (q_pop),
      .pop_token  (pop_token),
      .status     (q_status)
   );

   utl1_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_token  (pop_token),
      .q_status (q_status),
      .q_pop    (q_pop),
      .rsp_if   (rsp_if)
   );

endmodule
